>>> sv/actuator_disk_cell_source_core_defines.svh
// ----------------------------------------------------------------------------
// actuator disk cell source: assertion macros
// Shared macros for the port-level checks of the actuator disk core.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_DISK_CELL_SOURCE_CORE_DEFINES_SVH
`define ACTUATOR_DISK_CELL_SOURCE_CORE_DEFINES_SVH

// same-cycle implication, checks paused while reset is high
`define ADCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adcs port check failed");

// next-cycle implication, also checked across reset
`define ADCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("adcs port check failed");

`endif

>>> sv/adcs_pkg.sv
// ----------------------------------------------------------------------------
// adcs_pkg
// Types, register codes and sizing constants of the actuator disk core.
// ----------------------------------------------------------------------------
package adcs_pkg;

   // table size and port sizing
   localparam int TURBINES_DEF = 4;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int POS_W        = 64;

   // payload formats
   localparam int COORD_W  = 32;
   localparam int VEL_W    = 24;
   localparam int FORCE_W  = 32;
   localparam int WIDTH_W  = 31;
   localparam int RADIUS_W = 31;
   localparam int COUNT_W  = 3;
   localparam int RSQ_W    = 2 * RADIUS_W;

   // speed root
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int PROD_W  = VEL_W + ROOT_W;
   localparam int FORCE_SHIFT = 25;

   // pipeline depth, accepting edge to result edge
   localparam int FRONT_DEPTH = 4;
   localparam int BACK_DEPTH  = 3;
   localparam int LATENCY     = FRONT_DEPTH + ROOT_W + BACK_DEPTH;

   // saturation limits of the force magnitude
   localparam logic [FORCE_W-1:0] MAG_NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};
   localparam logic [FORCE_W-1:0] MAG_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};

   // register reset values
   localparam logic [WIDTH_W-1:0] CELL_WIDTH_RESET = WIDTH_W'(256);

   typedef enum logic [2:0] {
      REG_CELL_WIDTH    = 3'd0,
      REG_ROTOR_RADIUS  = 3'd1,
      REG_HUB_HEIGHT    = 3'd2,
      REG_TURBINE_COUNT = 3'd3,
      REG_TURBINE_0     = 3'd4,
      REG_TURBINE_1     = 3'd5,
      REG_TURBINE_2     = 3'd6,
      REG_TURBINE_3     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_low;
      logic signed [COORD_W-1:0] y_center;
      logic signed [COORD_W-1:0] z_center;
      logic signed [VEL_W-1:0]   velocity_x;
      logic signed [VEL_W-1:0]   velocity_y;
   } req_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic                      overlap_error;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]        cell_width_x;
      logic signed [COORD_W-1:0] hub_z;
      logic [RSQ_W-1:0]          radius_sq;
      logic [COUNT_W-1:0]        turbine_count;
   } geom_cfg_type;

   typedef struct packed {
      logic             hit;
      logic             overlap;
      logic             neg_u;
      logic             neg_v;
      logic [VEL_W-1:0] mag_u;
      logic [VEL_W-1:0] mag_v;
   } side_type;

endpackage

>>> sv/adcs_front.sv
// ----------------------------------------------------------------------------
// adcs_front
// Disk membership test per turbine and speed radicand, four register stages.
// ----------------------------------------------------------------------------
module adcs_front #(
   parameter int TURBINES = adcs_pkg::TURBINES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  adcs_pkg::req_type                       in_data,
   input  adcs_pkg::geom_cfg_type                  cfg,
   input  logic [TURBINES-1:0][adcs_pkg::POS_W-1:0] turbine_pos,
   output logic                                    out_valid,
   output logic [adcs_pkg::RAD_W-1:0]              out_radicand,
   output adcs_pkg::side_type                      out_side
);

   localparam int CW    = adcs_pkg::COORD_W;
   localparam int DW    = CW + 1;
   localparam int MW    = CW - 1;
   localparam int SQ_W  = 2 * MW;
   localparam int VW    = adcs_pkg::VEL_W;
   localparam int VSQ_W = 2 * VW;
   localparam int CNT_W = $clog2(TURBINES + 1);

   // stage a: differences and velocity magnitudes
   logic                  valid_a_ff;
   logic [DW-1:0]         dx_a_ff [TURBINES];
   logic [DW-1:0]         dx_a_in [TURBINES];
   logic [DW-1:0]         dy_a_ff [TURBINES];
   logic [DW-1:0]         dy_a_in [TURBINES];
   logic [DW-1:0]         dz_a_ff;
   logic [DW-1:0]         dz_a_in;
   adcs_pkg::side_type    side_a_ff;
   adcs_pkg::side_type    side_a_in;

   // stage b: candidate flags, distance magnitudes, velocity squares
   logic                  valid_b_ff;
   logic [DW-1:0]         dy_abs [TURBINES];
   logic [DW-1:0]         dz_abs;
   logic [TURBINES-1:0]   cand_b_ff;
   logic [TURBINES-1:0]   cand_b_in;
   logic [MW-1:0]         dym_b_ff [TURBINES];
   logic [MW-1:0]         dym_b_in [TURBINES];
   logic [MW-1:0]         dzm_b_ff;
   logic [VSQ_W-1:0]      usq_b_ff;
   logic [VSQ_W-1:0]      vsq_b_ff;
   adcs_pkg::side_type    side_b_ff;

   // stage c: distance squares and radicand
   logic                  valid_c_ff;
   logic [TURBINES-1:0]   cand_c_ff;
   logic [SQ_W-1:0]       sqy_c_ff [TURBINES];
   logic [SQ_W-1:0]       sqz_c_ff;
   logic [VSQ_W-1:0]      vel_sum;
   logic [adcs_pkg::RAD_W-1:0] rad_c_ff;
   adcs_pkg::side_type    side_c_ff;

   // stage d: disk test and hit count
   logic                  valid_d_ff;
   logic [TURBINES-1:0]   in_disk;
   logic [CNT_W-1:0]      hit_cnt;
   adcs_pkg::side_type    side_d_ff;
   adcs_pkg::side_type    side_d_in;
   logic [adcs_pkg::RAD_W-1:0] rad_d_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
      end
   end

   // stage a logic
   always_comb begin
      for (int t = 0; t < TURBINES; t++) begin
         dx_a_in[t] = {turbine_pos[t][adcs_pkg::POS_W-1],
                       turbine_pos[t][adcs_pkg::POS_W-1 -: CW]}
                    - {in_data.x_low[CW-1], in_data.x_low};
         dy_a_in[t] = {in_data.y_center[CW-1], in_data.y_center}
                    - {turbine_pos[t][CW-1], turbine_pos[t][CW-1:0]};
      end
      dz_a_in = {in_data.z_center[CW-1], in_data.z_center}
              - {cfg.hub_z[CW-1], cfg.hub_z};
      side_a_in.hit     = 1'b0;
      side_a_in.overlap = 1'b0;
      side_a_in.neg_u   = !in_data.velocity_x[VW-1];
      side_a_in.neg_v   = !in_data.velocity_y[VW-1];
      side_a_in.mag_u   = in_data.velocity_x[VW-1] ? VW'(-in_data.velocity_x)
                                                   : in_data.velocity_x;
      side_a_in.mag_v   = in_data.velocity_y[VW-1] ? VW'(-in_data.velocity_y)
                                                   : in_data.velocity_y;
   end

   always_ff @(posedge clock) begin
      dx_a_ff   <= dx_a_in;
      dy_a_ff   <= dy_a_in;
      dz_a_ff   <= dz_a_in;
      side_a_ff <= side_a_in;
   end

   // stage b logic: x interval, active entry, distance range
   always_comb begin
      dz_abs = dz_a_ff[DW-1] ? DW'(-dz_a_ff) : dz_a_ff;
      for (int t = 0; t < TURBINES; t++) begin
         dy_abs[t]    = dy_a_ff[t][DW-1] ? DW'(-dy_a_ff[t]) : dy_a_ff[t];
         cand_b_in[t] = !dx_a_ff[t][DW-1]
                     && (dx_a_ff[t][CW-1:0] < {1'b0, cfg.cell_width_x})
                     && (cfg.turbine_count > adcs_pkg::COUNT_W'(t))
                     && (dy_abs[t][DW-1:MW] == '0)
                     && (dz_abs[DW-1:MW] == '0);
         dym_b_in[t]  = dy_abs[t][MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cand_b_ff <= cand_b_in;
      dym_b_ff  <= dym_b_in;
      dzm_b_ff  <= dz_abs[MW-1:0];
      usq_b_ff  <= VSQ_W'(side_a_ff.mag_u) * VSQ_W'(side_a_ff.mag_u);
      vsq_b_ff  <= VSQ_W'(side_a_ff.mag_v) * VSQ_W'(side_a_ff.mag_v);
      side_b_ff <= side_a_ff;
   end

   // stage c: squares, radicand at speed scale squared
   assign vel_sum = usq_b_ff + vsq_b_ff;

   always_ff @(posedge clock) begin
      for (int t = 0; t < TURBINES; t++) begin
         sqy_c_ff[t] <= SQ_W'(dym_b_ff[t]) * SQ_W'(dym_b_ff[t]);
      end
      sqz_c_ff  <= SQ_W'(dzm_b_ff) * SQ_W'(dzm_b_ff);
      cand_c_ff <= cand_b_ff;
      rad_c_ff  <= {vel_sum, 16'd0};
      side_c_ff <= side_b_ff;
   end

   // stage d: strict radius test, any hit and overlap
   always_comb begin
      hit_cnt = '0;
      for (int t = 0; t < TURBINES; t++) begin
         in_disk[t] = cand_c_ff[t]
                   && ((SQ_W+1)'(sqy_c_ff[t]) + (SQ_W+1)'(sqz_c_ff)
                       < (SQ_W+1)'(cfg.radius_sq));
         hit_cnt    = hit_cnt + CNT_W'(in_disk[t]);
      end
      side_d_in         = side_c_ff;
      side_d_in.hit     = |in_disk;
      side_d_in.overlap = hit_cnt > CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      side_d_ff <= side_d_in;
      rad_d_ff  <= rad_c_ff;
   end

   assign out_valid    = valid_d_ff;
   assign out_radicand = rad_d_ff;
   assign out_side     = side_d_ff;

endmodule

>>> sv/adcs_sqrt.sv
// ----------------------------------------------------------------------------
// adcs_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module adcs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [adcs_pkg::RAD_W-1:0]    in_radicand,
   input  adcs_pkg::side_type            in_side,
   output logic                          out_valid,
   output logic [adcs_pkg::ROOT_W-1:0]   out_root,
   output adcs_pkg::side_type            out_side
);

   localparam int RW  = adcs_pkg::ROOT_W;
   localparam int MW  = adcs_pkg::REM_W;
   localparam int NW  = adcs_pkg::RAD_W;

   // stage registers and the view each stage takes of its source
   logic [RW-1:0]        valid_ff;
   logic [MW-1:0]        rem_ff   [RW];
   logic [RW-1:0]        root_ff  [RW];
   logic [NW-1:0]        rad_ff   [RW];
   adcs_pkg::side_type   side_ff  [RW];

   logic                 valid_src [RW];
   logic [MW-1:0]        rem_src   [RW];
   logic [RW-1:0]        root_src  [RW];
   logic [NW-1:0]        rad_src   [RW];
   adcs_pkg::side_type   side_src  [RW];

   genvar k;
   generate
      for (k = 0; k < RW; k++) begin : g_stage
         logic [MW+1:0] cur;
         logic [MW+1:0] trial;
         logic [MW-1:0] rem_in;
         logic [RW-1:0] root_in;

         // source of this stage
         if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign rem_src[k]   = '0;
            assign root_src[k]  = '0;
            assign rad_src[k]   = in_radicand;
            assign side_src[k]  = in_side;
         end else begin : g_next
            assign valid_src[k] = valid_ff[k-1];
            assign rem_src[k]   = rem_ff[k-1];
            assign root_src[k]  = root_ff[k-1];
            assign rad_src[k]   = rad_ff[k-1];
            assign side_src[k]  = side_ff[k-1];
         end

         // restoring step on the next two radicand bits
         always_comb begin
            cur   = {rem_src[k], rad_src[k][NW-1-2*k -: 2]};
            trial = {2'b00, root_src[k], 2'b01};
            if (cur >= trial) begin
               rem_in  = MW'(cur - trial);
               root_in = {root_src[k][RW-2:0], 1'b1};
            end else begin
               rem_in  = cur[MW-1:0];
               root_in = {root_src[k][RW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_src[k];
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   endgenerate

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

>>> sv/actuator_disk_cell_source_core.sv
// ----------------------------------------------------------------------------
// actuator_disk_cell_source_core
// Actuator disk momentum source for one grid cell per request.
// ----------------------------------------------------------------------------
// A request (cell lower x face, centre y and z, horizontal velocity) is taken
// at a clock edge with start high and busy low. Every cell is tested against
// the active turbine disks; inside a disk the block returns -0.5*u*|V| and
// -0.5*v*|V| in Q15.16, else zeros, and flags a cell inside several disks.
// Throughput: one request per cycle, sustained. Between the accepting edge
// and the edge that takes the result lie four geometry stages, then the
// 32-stage speed root, one root bit per stage, which makes up most of the
// path, then multiply, round and sign stages.
// Results come out in request order on rsp_data, qualified by rsp_strobe for
// exactly one cycle; the receiver cannot hold them off and the pipeline never
// stalls. The user must write registers through the APB port only while no
// request is in flight (not enforced); 64-bit registers: byte address 8*index.
// Reset is synchronous: it empties the pipeline, loads the register reset
// values and holds busy high until the cycle after reset is released.
// ----------------------------------------------------------------------------
module actuator_disk_cell_source_core #(
   parameter int TURBINES = adcs_pkg::TURBINES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  adcs_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output adcs_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [adcs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adcs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adcs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int FW = adcs_pkg::FORCE_W;
   localparam int PW = adcs_pkg::PROD_W;
   localparam int SH = adcs_pkg::FORCE_SHIFT;

   // register file
   logic                                    busy_ff;
   logic [adcs_pkg::WIDTH_W-1:0]            cell_width_ff;
   logic [adcs_pkg::RADIUS_W-1:0]           rotor_radius_ff;
   logic [adcs_pkg::COORD_W-1:0]            hub_z_ff;
   logic [adcs_pkg::COUNT_W-1:0]            turbine_count_ff;
   logic [TURBINES-1:0][adcs_pkg::POS_W-1:0] turbine_pos_ff;
   logic [adcs_pkg::RSQ_W-1:0]              radius_sq_ff;
   logic                                    csr_write;
   adcs_pkg::reg_index_type                 csr_index;
   logic [2:0]                              csr_pos_sel;
   adcs_pkg::geom_cfg_type                  geom_cfg;

   // pipeline
   logic                                    accept;
   logic                                    front_valid;
   logic [adcs_pkg::RAD_W-1:0]              front_radicand;
   adcs_pkg::side_type                      front_side;
   logic                                    root_valid;
   logic [adcs_pkg::ROOT_W-1:0]             root_value;
   adcs_pkg::side_type                      root_side;

   logic                                    valid_m_ff;
   logic [PW-1:0]                           prod_u_m_ff;
   logic [PW-1:0]                           prod_v_m_ff;
   adcs_pkg::side_type                      side_m_ff;

   logic                                    valid_r_ff;
   logic [FW-1:0]                           mag_u_r_ff;
   logic [FW-1:0]                           mag_u_r_in;
   logic [FW-1:0]                           mag_v_r_ff;
   logic [FW-1:0]                           mag_v_r_in;
   adcs_pkg::side_type                      side_r_ff;

   logic                                    rsp_strobe_ff;
   adcs_pkg::rsp_type                       rsp_data_ff;
   adcs_pkg::rsp_type                       rsp_data_in;

   // rounded, saturated force magnitude
   function automatic logic [FW-1:0] force_mag(input logic [PW-1:0] prod,
                                               input logic          neg);
      logic [PW:0]   sum;
      logic [FW-1:0] m;
      sum = {1'b0, prod} + (PW+1)'(2**(SH-1));
      m   = sum[SH +: FW];
      if (neg) begin
         force_mag = (m > adcs_pkg::MAG_NEG_MAX) ? adcs_pkg::MAG_NEG_MAX : m;
      end else begin
         force_mag = (m > adcs_pkg::MAG_POS_MAX) ? adcs_pkg::MAG_POS_MAX : m;
      end
   endfunction

   // request handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // register writes
   assign csr_write   = psel && penable && pwrite;
   assign csr_index   = adcs_pkg::reg_index_type'(paddr[adcs_pkg::CSR_ADDR_W-1 -: 3]);
   assign csr_pos_sel = csr_index - adcs_pkg::REG_TURBINE_0;
   assign pready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff    <= adcs_pkg::CELL_WIDTH_RESET;
         rotor_radius_ff  <= '0;
         hub_z_ff         <= '0;
         turbine_count_ff <= '0;
         turbine_pos_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            adcs_pkg::REG_CELL_WIDTH: begin
               cell_width_ff <= pwdata[adcs_pkg::WIDTH_W-1:0];
            end
            adcs_pkg::REG_ROTOR_RADIUS: begin
               rotor_radius_ff <= pwdata[adcs_pkg::RADIUS_W-1:0];
            end
            adcs_pkg::REG_HUB_HEIGHT: begin
               hub_z_ff <= pwdata[adcs_pkg::COORD_W-1:0];
            end
            adcs_pkg::REG_TURBINE_COUNT: begin
               turbine_count_ff <= pwdata[adcs_pkg::COUNT_W-1:0];
            end
            adcs_pkg::REG_TURBINE_0, adcs_pkg::REG_TURBINE_1,
            adcs_pkg::REG_TURBINE_2, adcs_pkg::REG_TURBINE_3: begin
               for (int t = 0; t < TURBINES; t++) begin
                  if (csr_pos_sel == 3'(t)) begin
                     turbine_pos_ff[t] <= pwdata;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      prdata = '0;
      case (csr_index)
         adcs_pkg::REG_CELL_WIDTH:    prdata = 64'(cell_width_ff);
         adcs_pkg::REG_ROTOR_RADIUS:  prdata = 64'(rotor_radius_ff);
         adcs_pkg::REG_HUB_HEIGHT:    prdata = 64'(hub_z_ff);
         adcs_pkg::REG_TURBINE_COUNT: prdata = 64'(turbine_count_ff);
         adcs_pkg::REG_TURBINE_0, adcs_pkg::REG_TURBINE_1,
         adcs_pkg::REG_TURBINE_2, adcs_pkg::REG_TURBINE_3: begin
            for (int t = 0; t < TURBINES; t++) begin
               if (csr_pos_sel == 3'(t)) begin
                  prdata = turbine_pos_ff[t];
               end
            end
         end
         default: prdata = '0;
      endcase
   end

   // squared radius follows the radius register in the next cycle
   always_ff @(posedge clock) begin
      radius_sq_ff <= adcs_pkg::RSQ_W'(rotor_radius_ff)
                    * adcs_pkg::RSQ_W'(rotor_radius_ff);
   end

   assign geom_cfg.cell_width_x  = cell_width_ff;
   assign geom_cfg.hub_z         = hub_z_ff;
   assign geom_cfg.radius_sq     = radius_sq_ff;
   assign geom_cfg.turbine_count = turbine_count_ff;

   // disk test and radicand
   adcs_front #(
      .TURBINES (TURBINES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_data      (req_data),
      .cfg          (geom_cfg),
      .turbine_pos  (turbine_pos_ff),
      .out_valid    (front_valid),
      .out_radicand (front_radicand),
      .out_side     (front_side)
   );

   // speed root
   adcs_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .in_radicand (front_radicand),
      .in_side     (front_side),
      .out_valid   (root_valid),
      .out_root    (root_value),
      .out_side    (root_side)
   );

   // back end valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m_ff    <= 1'b0;
         valid_r_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_m_ff    <= root_valid;
         valid_r_ff    <= valid_m_ff;
         rsp_strobe_ff <= valid_r_ff;
      end
   end

   // component times speed
   always_ff @(posedge clock) begin
      prod_u_m_ff <= PW'(root_side.mag_u) * PW'(root_value);
      prod_v_m_ff <= PW'(root_side.mag_v) * PW'(root_value);
      side_m_ff   <= root_side;
   end

   // round half up and saturate
   assign mag_u_r_in = force_mag(prod_u_m_ff, side_m_ff.neg_u);
   assign mag_v_r_in = force_mag(prod_v_m_ff, side_m_ff.neg_v);

   always_ff @(posedge clock) begin
      mag_u_r_ff <= mag_u_r_in;
      mag_v_r_ff <= mag_v_r_in;
      side_r_ff  <= side_m_ff;
   end

   // sign opposite to the velocity, zero outside every disk
   always_comb begin
      if (side_r_ff.hit) begin
         rsp_data_in.force_x = side_r_ff.neg_u ? FW'(-mag_u_r_ff) : mag_u_r_ff;
         rsp_data_in.force_y = side_r_ff.neg_v ? FW'(-mag_v_r_ff) : mag_v_r_ff;
      end else begin
         rsp_data_in.force_x = '0;
         rsp_data_in.force_y = '0;
      end
      rsp_data_in.overlap_error = side_r_ff.overlap;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> sv/adcs_checker.sv
// ----------------------------------------------------------------------------
// adcs_checker
// Port-level checks of the actuator disk core, bound to the top level.
// ----------------------------------------------------------------------------
`include "actuator_disk_cell_source_core_defines.svh"

module adcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input adcs_pkg::req_type req_data,
   input logic              rsp_strobe,
   input adcs_pkg::rsp_type rsp_data
);

   // pipeline is empty right after reset
   `ADCS_ASSERT_NEXT(a_reset_flush, reset, !rsp_strobe)

   // every accepted request gives one result after the fixed latency
   `ADCS_ASSERT_SAME(a_request_result, start && !busy, ##(adcs_pkg::LATENCY) rsp_strobe)

   // no result without a request at the matching edge
   `ADCS_ASSERT_SAME(a_no_phantom, rsp_strobe, $past(start && !busy, adcs_pkg::LATENCY))

   // x force never points along a positive or zero x velocity
   `ADCS_ASSERT_SAME(a_force_sign, rsp_strobe && !$past(req_data.velocity_x[adcs_pkg::VEL_W-1], adcs_pkg::LATENCY), rsp_data.force_x[adcs_pkg::FORCE_W-1] || (rsp_data.force_x == '0))

endmodule

bind actuator_disk_cell_source_core adcs_checker u_adcs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
